FILE: hw/rtl/string_keyed_direct_table_top_macros.svh
// ----------------------------------------------------------------------------
// string keyed direct table assertion macros
// shared concurrent assertion forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef STRING_KEYED_DIRECT_TABLE_TOP_MACROS_SVH
`define STRING_KEYED_DIRECT_TABLE_TOP_MACROS_SVH

// same-cycle implication
`define SKDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/skdt_pkg.sv
// ----------------------------------------------------------------------------
// skdt_pkg
// types and constants shared by the string keyed direct table
// ----------------------------------------------------------------------------
package skdt_pkg;

  localparam int SLOT_BITS     = 6;
  localparam int TABLE_ENTRIES = 1 << SLOT_BITS;

  // rolling hash constants
  localparam int             STEP_BITS   = 3;
  localparam int             WEIGHT_BITS = 1 << STEP_BITS;
  localparam logic [7:0]     HASH_BASE   = 8'd31;
  localparam logic [29:0]    HASH_MOD    = 30'd1000000009;
  localparam logic [9:0]     CHAR_OFFSET = 10'd96;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  key_char;
    logic        key_last;
    logic [31:0] put_value;
  } item_t;

  typedef struct packed {
    logic [31:0]          slot_value;
    logic [SLOT_BITS-1:0] slot_index;
    logic                 stored;
  } result_t;

  typedef struct packed {
    logic [1:0]           operation;
    logic [SLOT_BITS-1:0] slot_index;
    logic [31:0]          put_value;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_ACC,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

FILE: hw/rtl/skdt_front.sv
// ----------------------------------------------------------------------------
// skdt_front
// accepts key characters and runs the modular rolling hash, one bit per cycle
// ----------------------------------------------------------------------------
`include "string_keyed_direct_table_top_macros.svh"

module skdt_front import skdt_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  item_t key_item,
  input  logic  key_valid,
  output logic  key_ready,
  output job_t  job,
  output logic  push,
  input  logic  full
);

  front_state_t         state;
  front_state_t         state_next;
  logic [STEP_BITS-1:0] cnt;
  logic [29:0]          acc;
  logic [29:0]          pow;
  logic [29:0]          wprod;
  logic [29:0]          pprod;
  logic [WEIGHT_BITS-1:0] mag;
  logic                 neg;
  item_t                item;

  logic signed [9:0]    weight;
  logic [WEIGHT_BITS-1:0] mag_in;
  logic [31:0]          wsum;
  logic [31:0]          psum;
  logic [30:0]          sum;
  logic [30:0]          diff;
  logic [29:0]          acc_new;

  // fold a value below three times the modulus back into range
  function automatic logic [29:0] mod_fold(input logic [31:0] x);
    logic [31:0] m1;
    logic [31:0] m2;
    m1 = {2'b00, HASH_MOD};
    m2 = {1'b0, HASH_MOD, 1'b0};
    if (x >= m2) begin
      mod_fold = 30'(x - m2);
    end else if (x >= m1) begin
      mod_fold = 30'(x - m1);
    end else begin
      mod_fold = 30'(x);
    end
  endfunction

  always_comb begin
    weight = $signed({{2{key_item.key_char[7]}}, key_item.key_char}) - $signed(CHAR_OFFSET);
    mag_in = weight[9] ? WEIGHT_BITS'(-weight) : weight[WEIGHT_BITS-1:0];
  end

  // horner step, msb first: r = 2r + bit * pow
  always_comb begin
    wsum = {1'b0, wprod, 1'b0} + (mag[cnt] ? {2'b00, pow} : 32'd0);
    psum = {1'b0, pprod, 1'b0} + (HASH_BASE[cnt] ? {2'b00, pow} : 32'd0);
  end

  always_comb begin
    sum  = {1'b0, acc} + {1'b0, wprod};
    diff = {1'b0, acc} - {1'b0, wprod};
    if (neg) begin
      acc_new = diff[30] ? 30'(diff + {1'b0, HASH_MOD}) : diff[29:0];
    end else begin
      acc_new = (sum >= {1'b0, HASH_MOD}) ? 30'(sum - {1'b0, HASH_MOD}) : sum[29:0];
    end
  end

  always_comb begin
    state_next = state;
    key_ready  = 1'b0;
    push       = 1'b0;
    case (state)
      F_IDLE: begin
        key_ready = 1'b1;
        if (key_valid) begin
          state_next = F_MUL;
        end
      end
      F_MUL: begin
        if (cnt == '0) begin
          state_next = F_ACC;
        end
      end
      F_ACC: begin
        state_next = item.key_last ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  always_comb begin
    job.operation  = item.operation;
    job.slot_index = acc[SLOT_BITS-1:0];
    job.put_value  = item.put_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pow <= 30'd1;
    end else begin
      case (state)
        F_ACC: begin
          acc <= acc_new;
          pow <= pprod;
        end
        F_PUSH: begin
          if (!full) begin
            acc <= '0;
            pow <= 30'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (key_valid && key_ready) begin
      item  <= key_item;
      mag   <= mag_in;
      neg   <= weight[9];
      cnt   <= STEP_BITS'(WEIGHT_BITS - 1);
      wprod <= '0;
      pprod <= '0;
    end else if (state == F_MUL) begin
      wprod <= mod_fold(wsum);
      pprod <= mod_fold(psum);
      cnt   <= cnt - 1'b1;
    end
  end

  `SKDT_ASSERT_NOW(a_hash_in_range, 1'b1, (acc < HASH_MOD) && (pow < HASH_MOD) && (pow != '0), "hash state out of range")
  `SKDT_ASSERT_NEXT(a_mul_to_acc, (state == F_MUL) && (cnt == '0), state == F_ACC, "multiply loop did not finish")
  `SKDT_ASSERT_NOW(a_push_on_last, state == F_PUSH, item.key_last, "push without final character")

endmodule

FILE: hw/rtl/skdt_queue.sv
// ----------------------------------------------------------------------------
// skdt_queue
// short job queue between the hash front end and the table back end
// ----------------------------------------------------------------------------
module skdt_queue import skdt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  job_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  always_comb begin
    full    = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
    empty   = (count == '0);
    do_push = push && !full;
    do_pop  = pop && !empty;
    pop_job = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

FILE: hw/rtl/skdt_back.sv
// ----------------------------------------------------------------------------
// skdt_back
// applies put, remove and get to the slot table and holds the result
// ----------------------------------------------------------------------------
`include "string_keyed_direct_table_top_macros.svh"

module skdt_back import skdt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  job_t    head,
  input  logic    empty,
  output logic    pop,
  output result_t result_item,
  output logic    result_valid,
  input  logic    result_ready
);

  back_state_t              state;
  back_state_t              state_next;
  job_t                     job;
  logic [31:0]              mem [TABLE_ENTRIES];
  logic [31:0]              rd_data;
  logic [TABLE_ENTRIES-1:0] valid_bits;
  logic [31:0]              prior_value;
  logic                     do_store;
  logic                     exec;

  always_comb begin
    exec        = (state == B_EXEC);
    pop         = (state == B_IDLE) && !empty && (!result_valid || result_ready);
    // a slot never written since reset reads as empty
    prior_value = valid_bits[job.slot_index] ? rd_data : '0;
    do_store    = (job.operation == OP_PUT) && (prior_value == '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (pop) begin
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        state_next = B_IDLE;
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[head.slot_index];
    end
    if (exec && do_store) begin
      mem[job.slot_index] <= job.put_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (exec) begin
        if (do_store) begin
          valid_bits[job.slot_index] <= 1'b1;
        end else if (job.operation == OP_REMOVE) begin
          valid_bits[job.slot_index] <= 1'b0;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= head;
    end
    if (exec) begin
      result_item.slot_value <= prior_value;
      result_item.slot_index <= job.slot_index;
      result_item.stored     <= do_store;
    end
  end

  `SKDT_ASSERT_NOW(a_exec_output_free, exec, !result_valid, "result overwritten before taken")
  `SKDT_ASSERT_NEXT(a_put_marks_slot, exec && do_store, valid_bits[$past(job.slot_index)], "stored slot not marked")
  `SKDT_ASSERT_NEXT(a_remove_clears_slot, exec && (job.operation == OP_REMOVE), !valid_bits[$past(job.slot_index)], "removed slot still marked")

endmodule

FILE: hw/rtl/string_keyed_direct_table_top.sv
// ----------------------------------------------------------------------------
// string_keyed_direct_table_top
// direct-mapped value table addressed by a rolling hash of a streamed key
// ----------------------------------------------------------------------------
// Keys stream in one character per transaction; the last character carries the
// operation and the put value and yields one result. Each character passes
// through the hash front end as an accept step, the bit-serial modular multiply
// loop and an accumulate step; the last character then hands its job to a
// two-entry queue. The table back end takes each job through a registered
// memory read, then an update, so the hash loop sets the rate. The table comes
// out of reset empty with no clearing pass; a result waiting on the output
// stalls the front end only once two more jobs sit in the queue behind it.
module string_keyed_direct_table_top import skdt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   key_item,
  input  logic    key_valid,
  output logic    key_ready,
  output result_t result_item,
  output logic    result_valid,
  input  logic    result_ready
);

  job_t push_job;
  job_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  skdt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .key_item  (key_item),
    .key_valid (key_valid),
    .key_ready (key_ready),
    .job       (push_job),
    .push      (push),
    .full      (full)
  );

  skdt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (head),
    .empty    (empty)
  );

  skdt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_item  (result_item),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

FILE: dv/tb_string_keyed_direct_table_top.sv
// ----------------------------------------------------------------------------
// tb_string_keyed_direct_table_top
// streams keys one character per transaction into the hashed value table and
// checks each result against a predictor of the rolling hash and slot store or
// a typed row's want; directed edge cases first, then random keys drawn partly
// from a small reused pool so that puts, collisions and removes meet again
// ----------------------------------------------------------------------------
module tb_string_keyed_direct_table_top import skdt_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ROLL_BASE     = 31;
  localparam longint ROLL_MOD      = 1000000009;
  localparam longint WEIGHT_OFFSET = 96;

  localparam logic [1:0] OP_CODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1050;
  localparam int POOL_KEYS    = 12;
  localparam int MAX_KEY_LEN  = 12;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    item_t   item;
    bit      typed;
    result_t want;
  } directed_row_t;

  logic    clk;
  logic    rst;
  item_t   key_item;
  logic    key_valid;
  logic    key_ready;
  result_t result_item;
  logic    result_valid;
  logic    result_ready;

  // predictor state
  longint      hash_acc;
  longint      hash_pow;
  logic [31:0] slot_mirror [TABLE_ENTRIES];

  result_t       pending_results [$];
  directed_row_t directed_rows [$];
  result_t       head_result;

  int  error_count;
  int  chars_sent;
  int  results_checked;
  int  puts_taken;
  int  puts_refused;
  int  tx_idle_pct;
  bit  long_hold_req;

  logic [7:0] key_pool [POOL_KEYS][MAX_KEY_LEN];
  int         key_pool_len [POOL_KEYS];

  string_keyed_direct_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .key_item     (key_item),
    .key_valid    (key_valid),
    .key_ready    (key_ready),
    .result_item  (result_item),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb_string_keyed_direct_table_top: errors");
    $finish;
  end

  // advances the rolling hash by one character; on the last one it looks up
  // the slot mirror, applies a put or remove and returns the result to expect
  function automatic bit hash_and_apply(input item_t it, output result_t res);
    longint      weight;
    longint      sum;
    int          slot;
    logic [31:0] prior;
    weight   = longint'(signed'(it.key_char)) - WEIGHT_OFFSET;
    sum      = (hash_acc + weight * hash_pow) % ROLL_MOD;
    if (sum < 0) sum += ROLL_MOD;
    hash_acc = sum;
    hash_pow = (hash_pow * ROLL_BASE) % ROLL_MOD;
    res      = '0;
    if (!it.key_last) return 1'b0;
    slot           = int'(hash_acc % TABLE_ENTRIES);
    prior          = slot_mirror[slot];
    res.slot_value = prior;
    res.slot_index = slot[SLOT_BITS-1:0];
    case (it.operation)
      OP_PUT: begin
        if (prior == '0) begin
          slot_mirror[slot] = it.put_value;
          res.stored        = 1'b1;
        end
      end
      OP_REMOVE: begin
        slot_mirror[slot] = '0;
      end
      default: ;
    endcase
    hash_acc = 0;
    hash_pow = 1;
    return 1'b1;
  endfunction

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] random_key_char();
    if ($urandom_range(0, 99) < 60) return 8'h61 + 8'($urandom_range(0, 25));
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [31:0] random_put_value();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return $urandom;
  endfunction

  // holds one character on the input until the table takes it
  task automatic offer_char(input item_t it);
    result_t res;
    key_item  <= it;
    key_valid <= 1'b1;
    do @(posedge clk); while (!key_ready);
    chars_sent++;
    if (hash_and_apply(it, res)) pending_results.push_back(res);
  endtask

  task automatic sender_gap();
    int n;
    n = idle_length();
    key_valid <= 1'b0;
    key_item  <= item_t'({$urandom, $urandom});
    repeat (n) @(posedge clk);
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] ch, input logic last,
                         input logic [31:0] value, input bit typed,
                         input logic [31:0] want_value, input logic [SLOT_BITS-1:0] want_slot,
                         input logic want_stored);
    directed_row_t row;
    row.item.operation  = op;
    row.item.key_char   = ch;
    row.item.key_last   = last;
    row.item.put_value  = value;
    row.typed           = typed;
    row.want.slot_value = want_value;
    row.want.slot_index = want_slot;
    row.want.stored     = want_stored;
    directed_rows.push_back(row);
  endtask

  task automatic send_key(input logic [7:0] chars [MAX_KEY_LEN], input int len);
    item_t it;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < tx_idle_pct) sender_gap();
      it.key_char  = chars[i];
      it.key_last  = (i == len - 1);
      it.operation = 2'($urandom_range(0, 3));
      it.put_value = random_put_value();
      offer_char(it);
    end
  endtask

  function automatic int random_key_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 4);
    return $urandom_range(5, MAX_KEY_LEN);
  endfunction

  // receiver: random back-pressure windows plus one long hold-off
  initial begin
    int idle_pct;
    int window;
    result_ready = 1'b0;
    idle_pct     = 0;
    window       = 0;
    forever begin
      @(posedge clk);
      if (window == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 40;
        endcase
        window = 200;
      end
      window--;
      if (rst) begin
        result_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        result_ready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction waiting: value %h slot %0d stored %0b",
               result_item.slot_value, result_item.slot_index, result_item.stored);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        results_checked++;
        if (head_result.stored) puts_taken++;
        if (result_item.slot_value !== head_result.slot_value) begin
          $error("slot_value: expected %h, got %h",
                 head_result.slot_value, result_item.slot_value);
          error_count++;
        end
        if (result_item.slot_index !== head_result.slot_index) begin
          $error("slot_index: expected %0d, got %0d",
                 head_result.slot_index, result_item.slot_index);
          error_count++;
        end
        if (result_item.stored !== head_result.stored) begin
          $error("stored: expected %0b, got %0b", head_result.stored, result_item.stored);
          error_count++;
        end
      end
    end
  end

  initial begin
    result_t    res;
    int         slot_pick;
    int         keys_done;
    logic [7:0] fresh [MAX_KEY_LEN];
    int         fresh_len;

    rst             = 1'b1;
    key_valid       = 1'b0;
    key_item        = '0;
    long_hold_req   = 1'b0;
    error_count     = 0;
    chars_sent      = 0;
    results_checked = 0;
    puts_taken      = 0;
    puts_refused    = 0;
    tx_idle_pct     = 20;
    hash_acc        = 0;
    hash_pow        = 1;
    foreach (slot_mirror[i]) slot_mirror[i] = '0;

    // single 'a' hashes to slot 1, '`' to slot 0, 8'h7f to slot 31
    add_row(OP_GET,         8'h61, 1'b1, 32'h0,        1, 32'h0,        6'd1,  1'b0);
    add_row(OP_PUT,         8'h61, 1'b1, 32'hFFFFFFFF, 1, 32'h0,        6'd1,  1'b1);
    add_row(OP_PUT,         8'h61, 1'b1, 32'h00000012, 1, 32'hFFFFFFFF, 6'd1,  1'b0);
    add_row(OP_GET,         8'h61, 1'b1, 32'h0,        1, 32'hFFFFFFFF, 6'd1,  1'b0);
    add_row(OP_REMOVE,      8'h61, 1'b1, 32'h0,        1, 32'hFFFFFFFF, 6'd1,  1'b0);
    add_row(OP_CODE_UNUSED, 8'h61, 1'b1, 32'h5,        1, 32'h0,        6'd1,  1'b0);
    add_row(OP_PUT,         8'h60, 1'b1, 32'h0,        1, 32'h0,        6'd0,  1'b1);
    add_row(OP_GET,         8'h60, 1'b1, 32'h0,        1, 32'h0,        6'd0,  1'b0);
    add_row(OP_PUT,         8'h7F, 1'b1, 32'h80000001, 1, 32'h0,        6'd31, 1'b1);
    // operations on inner characters must be ignored
    add_row(OP_REMOVE,      8'hFF, 1'b0, 32'hFFFFFFFF, 0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'h00, 1'b0, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_REMOVE,      8'h80, 1'b1, 32'h0,        0, '0, '0, 1'b0);
    // zero byte and 8'h80 land on the same slot
    add_row(OP_PUT,         8'h00, 1'b1, 32'hA5A5A5A5, 0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'h80, 1'b1, 32'h5A5A5A5A, 0, '0, '0, 1'b0);
    add_row(OP_GET,         8'h80, 1'b1, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_GET,         8'h68, 1'b0, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'h69, 1'b1, 32'h00000001, 0, '0, '0, 1'b0);
    add_row(OP_GET,         8'h68, 1'b0, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_GET,         8'h69, 1'b1, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_REMOVE,      8'h00, 1'b1, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_GET,         8'h7F, 1'b1, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'hFF, 1'b0, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'hFF, 1'b0, 32'h0,        0, '0, '0, 1'b0);
    add_row(OP_PUT,         8'hFF, 1'b1, 32'h7FFFFFFF, 0, '0, '0, 1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if ($urandom_range(0, 99) < tx_idle_pct) sender_gap();
      key_item  <= directed_rows[r].item;
      key_valid <= 1'b1;
      do @(posedge clk); while (!key_ready);
      chars_sent++;
      if (hash_and_apply(directed_rows[r].item, res)) begin
        if (directed_rows[r].typed) pending_results.push_back(directed_rows[r].want);
        else pending_results.push_back(res);
      end
    end

    for (int k = 0; k < POOL_KEYS; k++) begin
      key_pool_len[k] = random_key_len();
      for (int c = 0; c < MAX_KEY_LEN; c++) key_pool[k][c] = random_key_char();
    end

    long_hold_req = 1'b1;
    keys_done     = 0;
    while (chars_sent < RANDOM_ITEMS) begin
      if (keys_done % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: tx_idle_pct = 0;
          1: tx_idle_pct = 20;
          default: tx_idle_pct = 50;
        endcase
      end
      if ($urandom_range(0, 99) < 70) begin
        slot_pick = $urandom_range(0, POOL_KEYS - 1);
        send_key(key_pool[slot_pick], key_pool_len[slot_pick]);
      end else begin
        fresh_len = random_key_len();
        for (int c = 0; c < MAX_KEY_LEN; c++) fresh[c] = 8'($urandom_range(0, 255));
        send_key(fresh, fresh_len);
        // occasionally swap a pool key for a new one
        if ($urandom_range(0, 9) == 0) begin
          slot_pick = $urandom_range(0, POOL_KEYS - 1);
          key_pool_len[slot_pick] = fresh_len;
          for (int c = 0; c < MAX_KEY_LEN; c++) key_pool[slot_pick][c] = fresh[c];
        end
      end
      keys_done++;
    end
    key_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    puts_refused = results_checked - puts_taken;
    $display("sent %0d key characters, checked %0d lookups (%0d puts written, %0d other)",
             chars_sent, results_checked, puts_taken, puts_refused);
    $display("covered sign-extended bytes, slot collisions, op code three and a long stall");
    if (error_count == 0) begin
      $display("tb_string_keyed_direct_table_top: clean");
    end else begin
      $display("tb_string_keyed_direct_table_top: errors");
    end
    $finish;
  end

endmodule
